// File: hdl/mva_pkg.sv
// shared constants, codes and control types for the midi voice allocator
package mva_pkg;

  localparam int NUM_VOICES = 16;
  localparam int VID_W      = $clog2(NUM_VOICES);
  localparam int AGE_BITS   = 32;
  localparam int NUM_CH     = 16;

  localparam logic [13:0] PITCH_CENTER = 14'h2000;
  localparam logic [6:0]  VEL_ONE      = 7'd127;

  // event codes
  localparam logic [2:0] REQ_NOTE_ON   = 3'd0;
  localparam logic [2:0] REQ_NOTE_OFF  = 3'd1;
  localparam logic [2:0] REQ_ALL_OFF   = 3'd2;
  localparam logic [2:0] REQ_SUSTAIN   = 3'd3;
  localparam logic [2:0] REQ_SOSTENUTO = 3'd4;
  localparam logic [2:0] REQ_PITCH     = 3'd5;
  localparam logic [2:0] REQ_ENDED     = 3'd6;

  // voice command codes
  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_START     = 2'd1;
  localparam logic [1:0] CMD_STOP_TAIL = 2'd2;
  localparam logic [1:0] CMD_STOP_NOW  = 2'd3;

  // register map
  localparam logic CFG_STEAL_ENABLE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_ALLOC,
    ST_PICK,
    ST_PICK_CHK,
    ST_STEAL_STOP,
    ST_START,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic             latch;
    logic             single;
    logic             scan_step;
    logic             pick_clear;
    logic             pick_step;
    logic             steal_stop;
    logic             start;
    logic             flush;
    logic [VID_W-1:0] idx;
    logic [1:0]       pass;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       ch_ok;
    logic       free_v;
    logic       best_v;
    logic       pend_v;
    logic       emit_ok;
    logic       can_push;
    logic       steal_en;
  } dp_status_t;

endpackage

// File: hdl/mva_if.sv
// event and command channel interfaces
interface mva_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [4:0]  channel;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic        pedal_down;
  logic [13:0] wheel_value;
  logic [5:0]  ended_voice;

  modport source (output valid, req_type, channel, note, velocity, pedal_down,
                  wheel_value, ended_voice, input ready);
  modport sink (input valid, req_type, channel, note, velocity, pedal_down,
                wheel_value, ended_voice, output ready);
endinterface

interface mva_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  voice_id;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;
  logic [4:0]  out_channel;
  logic [13:0] out_pitch;
  logic        last;

  modport source (output valid, command, voice_id, out_note, out_velocity, out_channel,
                  out_pitch, last, input ready);
  modport sink (input valid, command, voice_id, out_note, out_velocity, out_channel,
                out_pitch, last, output ready);
endinterface

// File: hdl/mva_dp.sv
// voice table, channel state, steal search registers and command output stage
module mva_dp
  import mva_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_cmd_t         cmd,
  output dp_status_t       status,
  input  logic             steal_en,
  input  logic [2:0]       in_req_type,
  input  logic [4:0]       in_channel,
  input  logic [6:0]       in_note,
  input  logic [6:0]       in_velocity,
  input  logic             in_pedal_down,
  input  logic [13:0]      in_wheel_value,
  input  logic [5:0]       in_ended_voice,
  mva_out_if.source        out_ch
);

  // latched event
  logic [2:0]  ev_type_r;
  logic [4:0]  ev_ch_r;
  logic [6:0]  ev_note_r;
  logic [6:0]  ev_vel_r;
  logic        ev_down_r;
  logic [13:0] ev_wheel_r;
  logic [5:0]  ev_ended_r;

  // voice table and channel state
  logic                va_r    [NUM_VOICES];
  logic [6:0]          vn_r    [NUM_VOICES];
  logic [4:0]          vc_r    [NUM_VOICES];
  logic [AGE_BITS-1:0] vage_r  [NUM_VOICES];
  logic                vkd_r   [NUM_VOICES];
  logic                vsus_r  [NUM_VOICES];
  logic                vsost_r [NUM_VOICES];
  logic [NUM_CH-1:0]   csus_r;
  logic [13:0]         cpitch_r [NUM_CH];
  logic [AGE_BITS-1:0] cnt_r;

  // search registers
  logic                free_v_r, low_v_r, top_v_r, best_v_r;
  logic [VID_W-1:0]    free_idx_r, low_idx_r, top_idx_r, best_idx_r;
  logic [6:0]          low_note_r, top_note_r;
  logic [AGE_BITS-1:0] best_age_r;

  // pending beat and output register
  logic        pend_v_r;
  logic [1:0]  pend_cmd_r;
  logic [5:0]  pend_vid_r;
  logic [6:0]  pend_note_r, pend_vel_r;
  logic [4:0]  pend_ch_r;
  logic [13:0] pend_pitch_r;
  logic        ov_r;
  logic [1:0]  o_cmd_r;
  logic [5:0]  o_vid_r;
  logic [6:0]  o_note_r, o_vel_r;
  logic [4:0]  o_ch_r;
  logic [13:0] o_pitch_r;
  logic        o_last_r;

  logic [VID_W-1:0] i;
  logic             act, kd, sus, sost, ch_match, match, released, prot, top_eff, cond;
  logic             ch_ok, can_push, emit_v, push, last_idx;
  logic [VID_W-1:0] sel, fallback;
  logic [3:0]       ch_idx;
  logic [4:0]       ch_m1;
  logic [1:0]       e_cmd;
  logic [6:0]       e_note, e_vel;
  logic [4:0]       e_ch;
  logic [13:0]      e_pitch;
  logic [VID_W-1:0] e_vid;
  logic [AGE_BITS-1:0] cnt_inc;

  // current voice of the scan
  assign i        = cmd.idx;
  assign act      = va_r[i];
  assign kd       = vkd_r[i];
  assign sus      = vsus_r[i];
  assign sost     = vsost_r[i];
  assign ch_match = vc_r[i] == ev_ch_r;
  assign match    = act && (vn_r[i] == ev_note_r) && ch_match;
  assign released = act && !(kd || sus || sost);
  assign last_idx = i == VID_W'(NUM_VOICES - 1);
  assign ch_ok    = (ev_ch_r >= 5'd1) && (ev_ch_r <= 5'(NUM_CH));
  assign ch_m1    = ev_ch_r - 5'd1;
  assign ch_idx   = ch_m1[3:0];
  assign cnt_inc  = cnt_r + AGE_BITS'(1);

  // voice selection: free voice, else steal winner, else protected fallback
  assign top_eff  = top_v_r && !(low_v_r && (top_idx_r == low_idx_r));
  assign fallback = top_eff ? top_idx_r : (low_v_r ? low_idx_r : '0);
  assign sel      = free_v_r ? free_idx_r : (best_v_r ? best_idx_r : fallback);

  // steal pass condition
  assign prot = (low_v_r && (i == low_idx_r)) || (top_eff && (i == top_idx_r));
  always_comb begin
    unique case (cmd.pass)
      2'd0:    cond = vn_r[i] == ev_note_r;
      2'd1:    cond = !prot && released;
      2'd2:    cond = !prot && !kd;
      default: cond = !prot;
    endcase
  end

  // beat produced in this cycle
  always_comb begin
    emit_v  = 1'b0;
    e_cmd   = CMD_STOP_TAIL;
    e_vid   = i;
    e_note  = 7'd0;
    e_vel   = VEL_ONE;
    e_ch    = 5'd0;
    e_pitch = 14'd0;
    if (cmd.start) begin
      emit_v  = 1'b1;
      e_cmd   = CMD_START;
      e_vid   = sel;
      e_note  = ev_note_r;
      e_vel   = ev_vel_r;
      e_ch    = ev_ch_r;
      e_pitch = cpitch_r[ch_idx];
    end else if (cmd.steal_stop) begin
      emit_v = 1'b1;
      e_cmd  = CMD_STOP_NOW;
      e_vid  = sel;
      e_vel  = 7'd0;
    end else if (cmd.scan_step) begin
      unique case (ev_type_r)
        REQ_NOTE_ON:   emit_v = match;
        REQ_NOTE_OFF: begin
          emit_v = match && !(sus || sost);
          e_vel  = ev_vel_r;
        end
        REQ_ALL_OFF:   emit_v = act && ((ev_ch_r == 5'd0) || ch_match);
        REQ_SUSTAIN:   emit_v = !ev_down_r && act && ch_match && !(kd || sost);
        REQ_SOSTENUTO: emit_v = !ev_down_r && act && ch_match && sost;
        default:       emit_v = 1'b0;
      endcase
    end
  end

  assign can_push = !ov_r || out_ch.ready;
  assign push     = pend_v_r && ((cmd.flush) || emit_v);

  // event latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ev_type_r  <= in_req_type;
      ev_ch_r    <= in_channel;
      ev_note_r  <= in_note;
      ev_vel_r   <= in_velocity;
      ev_down_r  <= in_pedal_down;
      ev_wheel_r <= in_wheel_value;
      ev_ended_r <= in_ended_voice;
    end
  end

  // voice table, channel state and search registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_VOICES; k++) begin
        va_r[k]    <= 1'b0;
        vn_r[k]    <= 7'd0;
        vc_r[k]    <= 5'd0;
        vage_r[k]  <= '0;
        vkd_r[k]   <= 1'b0;
        vsus_r[k]  <= 1'b0;
        vsost_r[k] <= 1'b0;
      end
      for (int k = 0; k < NUM_CH; k++) begin
        cpitch_r[k] <= PITCH_CENTER;
      end
      csus_r   <= '0;
      cnt_r    <= '0;
      free_v_r <= 1'b0;
      low_v_r  <= 1'b0;
      top_v_r  <= 1'b0;
      best_v_r <= 1'b0;
    end else begin
      if (cmd.latch) begin
        free_v_r <= 1'b0;
        low_v_r  <= 1'b0;
        top_v_r  <= 1'b0;
        best_v_r <= 1'b0;
      end
      // pitch wheel and voice ended events
      if (cmd.single) begin
        if (ev_type_r == REQ_PITCH && ch_ok) begin
          cpitch_r[ch_idx] <= ev_wheel_r;
        end
        if (ev_type_r == REQ_ENDED && ev_ended_r < 6'(NUM_VOICES)) begin
          va_r[ev_ended_r[VID_W-1:0]]    <= 1'b0;
          vn_r[ev_ended_r[VID_W-1:0]]    <= 7'd0;
          vc_r[ev_ended_r[VID_W-1:0]]    <= 5'd0;
          vkd_r[ev_ended_r[VID_W-1:0]]   <= 1'b0;
          vsus_r[ev_ended_r[VID_W-1:0]]  <= 1'b0;
          vsost_r[ev_ended_r[VID_W-1:0]] <= 1'b0;
        end
      end
      // per-voice scan updates
      if (cmd.scan_step) begin
        unique case (ev_type_r)
          REQ_NOTE_ON: begin
            if (!act && !free_v_r) begin
              free_v_r   <= 1'b1;
              free_idx_r <= i;
            end
            if (act && !released) begin
              if (!low_v_r || vn_r[i] < low_note_r) begin
                low_v_r    <= 1'b1;
                low_idx_r  <= i;
                low_note_r <= vn_r[i];
              end
              if (!top_v_r || vn_r[i] > top_note_r) begin
                top_v_r    <= 1'b1;
                top_idx_r  <= i;
                top_note_r <= vn_r[i];
              end
            end
          end
          REQ_NOTE_OFF: begin
            if (match) vkd_r[i] <= 1'b0;
          end
          REQ_ALL_OFF: begin
            if (last_idx) csus_r <= '0;
          end
          REQ_SUSTAIN: begin
            if (ev_down_r) begin
              if (act && ch_match && kd) vsus_r[i] <= 1'b1;
              if (last_idx) csus_r[ch_idx] <= 1'b1;
            end else begin
              if (act && ch_match) vsus_r[i] <= 1'b0;
              if (last_idx) csus_r[ch_idx] <= 1'b0;
            end
          end
          REQ_SOSTENUTO: begin
            if (ev_down_r && act && ch_match) vsost_r[i] <= 1'b1;
          end
          default: ;
        endcase
      end
      // oldest-first steal search, one voice per cycle
      if (cmd.pick_clear) begin
        best_v_r <= 1'b0;
      end else if (cmd.pick_step && cond && (!best_v_r || vage_r[i] < best_age_r)) begin
        best_v_r   <= 1'b1;
        best_idx_r <= i;
        best_age_r <= vage_r[i];
      end
      // voice start
      if (cmd.start) begin
        cnt_r         <= cnt_inc;
        va_r[sel]     <= 1'b1;
        vn_r[sel]     <= ev_note_r;
        vc_r[sel]     <= ev_ch_r;
        vage_r[sel]   <= cnt_inc;
        vkd_r[sel]    <= 1'b1;
        vsost_r[sel]  <= 1'b0;
        vsus_r[sel]   <= csus_r[ch_idx];
      end
    end
  end

  // one beat held back so the last one can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (emit_v) begin
        pend_v_r     <= 1'b1;
        pend_cmd_r   <= e_cmd;
        pend_vid_r   <= 6'(e_vid);
        pend_note_r  <= e_note;
        pend_vel_r   <= e_vel;
        pend_ch_r    <= e_ch;
        pend_pitch_r <= e_pitch;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
      if (push) begin
        ov_r      <= 1'b1;
        o_cmd_r   <= pend_cmd_r;
        o_vid_r   <= pend_vid_r;
        o_note_r  <= pend_note_r;
        o_vel_r   <= pend_vel_r;
        o_ch_r    <= pend_ch_r;
        o_pitch_r <= pend_pitch_r;
        o_last_r  <= cmd.flush;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.command      = o_cmd_r;
  assign out_ch.voice_id     = o_vid_r;
  assign out_ch.out_note     = o_note_r;
  assign out_ch.out_velocity = o_vel_r;
  assign out_ch.out_channel  = o_ch_r;
  assign out_ch.out_pitch    = o_pitch_r;
  assign out_ch.last         = o_last_r;

  assign status.req_type = ev_type_r;
  assign status.ch_ok    = ch_ok;
  assign status.free_v   = free_v_r;
  assign status.best_v   = best_v_r;
  assign status.pend_v   = pend_v_r;
  assign status.emit_ok  = !pend_v_r || can_push;
  assign status.can_push = can_push;
  assign status.steal_en = steal_en;

  // output register is never overwritten while a beat waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!ov_r || out_ch.ready))
    else $error("output beat overwritten");

  // a free voice handed out is really free
  a_free_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && free_v_r) |-> !va_r[sel])
    else $error("started voice was not free");

  // a started voice is active afterwards
  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> va_r[$past(sel)])
    else $error("started voice not active");

endmodule

// File: hdl/mva_ctrl.sv
// sequencer for event decode, voice scans, steal passes and beat flush
module mva_ctrl
  import mva_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  ctrl_state_t      state_r, state_nxt;
  logic [VID_W-1:0] idx_r, idx_nxt;
  logic [1:0]       pass_r, pass_nxt;
  logic             idx_last;

  assign idx_last = idx_r == VID_W'(NUM_VOICES - 1);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      pass_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.pass  = pass_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        idx_nxt = '0;
        unique case (status.req_type)
          REQ_NOTE_ON, REQ_SUSTAIN, REQ_SOSTENUTO:
            state_nxt = status.ch_ok ? ST_SCAN : ST_FLUSH;
          REQ_NOTE_OFF, REQ_ALL_OFF:
            state_nxt = ST_SCAN;
          REQ_PITCH, REQ_ENDED: begin
            cmd.single = 1'b1;
            state_nxt  = ST_FLUSH;
          end
          default:
            state_nxt = ST_FLUSH;
        endcase
      end
      ST_SCAN: begin
        if (status.emit_ok) begin
          cmd.scan_step = 1'b1;
          if (idx_last) begin
            state_nxt = (status.req_type == REQ_NOTE_ON) ? ST_ALLOC : ST_FLUSH;
          end else begin
            idx_nxt = idx_r + VID_W'(1);
          end
        end
      end
      ST_ALLOC: begin
        if (status.free_v) begin
          state_nxt = ST_START;
        end else if (status.steal_en) begin
          cmd.pick_clear = 1'b1;
          pass_nxt       = 2'd0;
          idx_nxt        = '0;
          state_nxt      = ST_PICK;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_PICK: begin
        cmd.pick_step = 1'b1;
        if (idx_last) begin
          state_nxt = ST_PICK_CHK;
        end else begin
          idx_nxt = idx_r + VID_W'(1);
        end
      end
      ST_PICK_CHK: begin
        if (status.best_v || pass_r == 2'd3) begin
          state_nxt = ST_STEAL_STOP;
        end else begin
          cmd.pick_clear = 1'b1;
          pass_nxt       = pass_r + 2'd1;
          idx_nxt        = '0;
          state_nxt      = ST_PICK;
        end
      end
      ST_STEAL_STOP: begin
        if (status.emit_ok) begin
          cmd.steal_stop = 1'b1;
          state_nxt      = ST_START;
        end
      end
      ST_START: begin
        if (status.emit_ok) begin
          cmd.start = 1'b1;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (status.can_push) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/midi_voice_allocator_core.sv
// Polyphonic voice allocator: takes one decoded MIDI event per input beat and
// returns its voice commands as a burst of output beats, the final one flagged
// by last. One event is in work at a time. Pitch wheel, voice ended and ignored
// events do not scan the voice table; other events scan the 16-entry voice
// table one voice per cycle while the output can take their beats. A note on
// with no free voice and stealing enabled adds up to four search passes over
// the table, then the stop and start. Output back-pressure stalls the scan,
// the stop and the start. Register 0 (address 0, bit 0) is steal_enable, reset to 1.
module midi_voice_allocator_core
  import mva_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mva_in_if.sink      in_ch,
  mva_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic       steal_en_r;
  logic       reg_sel;
  ctl_cmd_t   cmd;
  dp_status_t status;

  // configuration register
  assign reg_sel    = cfg_paddr[2] == CFG_STEAL_ENABLE;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? {31'd0, steal_en_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steal_en_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      steal_en_r <= cfg_pwdata[0];
    end
  end

  mva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mva_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .steal_en       (steal_en_r),
    .in_req_type    (in_ch.req_type),
    .in_channel     (in_ch.channel),
    .in_note        (in_ch.note),
    .in_velocity    (in_ch.velocity),
    .in_pedal_down  (in_ch.pedal_down),
    .in_wheel_value (in_ch.wheel_value),
    .in_ended_voice (in_ch.ended_voice),
    .out_ch         (out_ch)
  );

endmodule

// File: test/tb_midi_voice_allocator_core.sv
// testbench for the midi voice allocator core: directed table, random events, model check
`timescale 1ns / 100ps

module tb_midi_voice_allocator_core;
  import mva_pkg::*;

  typedef struct {
    logic [2:0]  req;
    logic [4:0]  ch;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic        down;
    logic [13:0] wheel;
    logic [5:0]  ended;
  } midi_event_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  vid;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [4:0]  ch;
    logic [13:0] pitch;
    logic        last;
    int          seq;
    bit          first;
  } voice_cmd_t;

  typedef struct {
    midi_event_t ev;
    logic [1:0]  pin_cmd;
    logic [5:0]  pin_vid;
  } table_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mva_in_if  in_bus ();
  mva_out_if out_bus ();

  midi_voice_allocator_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus.sink), .out_ch(out_bus.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // allocator shadow state
  bit          steal_on;
  bit          v_active [NUM_VOICES];
  logic [6:0]  v_note [NUM_VOICES];
  logic [4:0]  v_chan [NUM_VOICES];
  logic [31:0] v_age [NUM_VOICES];
  bit          v_key [NUM_VOICES];
  bit          v_sus [NUM_VOICES];
  bit          v_sost [NUM_VOICES];
  logic [15:0] chan_sus;
  logic [13:0] chan_pitch [NUM_CH];
  logic [31:0] start_count;

  voice_cmd_t  pending_cmds[$];
  logic [1:0]  pin_cmd [int];
  logic [5:0]  pin_vid [int];
  int          accepted_cnt;
  int          sent_cnt;
  int          errors;
  bit          calm;
  bit          hold_req;
  int          hold_cnt;
  int          out_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_released(int v);
    return v_active[v] && !(v_key[v] || v_sus[v] || v_sost[v]);
  endfunction

  function automatic void push_cmd(int seq, logic [1:0] cmd, int vid, logic [6:0] note,
                                   logic [6:0] vel, logic [4:0] ch, logic [13:0] pitch,
                                   ref int n);
    voice_cmd_t c;
    c.cmd = cmd; c.vid = vid[5:0]; c.note = note; c.vel = vel; c.ch = ch;
    c.pitch = pitch; c.last = 1'b0; c.seq = seq; c.first = (n == 0);
    pending_cmds.push_back(c);
    n++;
  endfunction

  // oldest first, protecting lowest and highest held notes
  function automatic int choose_victim(logic [6:0] note);
    int order [NUM_VOICES];
    int low, top, k;
    bit prot, ok;
    low = -1;
    top = -1;
    for (int i = 0; i < NUM_VOICES; i++) begin
      k = i;
      while (k > 0 && v_age[order[k-1]] > v_age[i]) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = i;
      if (!is_released(i)) begin
        if (low < 0 || v_note[i] < v_note[low]) low = i;
        if (top < 0 || v_note[i] > v_note[top]) top = i;
      end
    end
    if (top == low) top = -1;
    for (int p = 0; p < 4; p++) begin
      for (int j = 0; j < NUM_VOICES; j++) begin
        prot = (order[j] == low) || (order[j] == top);
        case (p)
          0: ok = v_note[order[j]] == note;
          1: ok = !prot && is_released(order[j]);
          2: ok = !prot && !v_key[order[j]];
          default: ok = !prot;
        endcase
        if (ok) return order[j];
      end
    end
    if (top >= 0) return top;
    return (low >= 0) ? low : 0;
  endfunction

  // apply one accepted event to the shadow state and queue its commands
  function automatic void apply_event(midi_event_t e, int seq);
    int n, sel;
    bit ch_ok;
    n = 0;
    ch_ok = e.ch >= 1 && e.ch <= 16;
    case (e.req)
      REQ_NOTE_ON: if (ch_ok) begin
        for (int v = 0; v < NUM_VOICES; v++)
          if (v_active[v] && v_note[v] == e.note && v_chan[v] == e.ch)
            push_cmd(seq, CMD_STOP_TAIL, v, 0, VEL_ONE, 0, 0, n);
        sel = -1;
        for (int v = NUM_VOICES - 1; v >= 0; v--)
          if (!v_active[v]) sel = v;
        if (sel < 0 && steal_on) sel = choose_victim(e.note);
        if (sel >= 0) begin
          if (v_active[sel]) push_cmd(seq, CMD_STOP_NOW, sel, 0, 0, 0, 0, n);
          start_count++;
          v_active[sel] = 1'b1;
          v_note[sel] = e.note;
          v_chan[sel] = e.ch;
          v_age[sel] = start_count;
          v_key[sel] = 1'b1;
          v_sost[sel] = 1'b0;
          v_sus[sel] = chan_sus[e.ch - 1];
          push_cmd(seq, CMD_START, sel, e.note, e.vel, e.ch, chan_pitch[e.ch - 1], n);
        end
      end
      REQ_NOTE_OFF:
        for (int v = 0; v < NUM_VOICES; v++)
          if (v_active[v] && v_note[v] == e.note && v_chan[v] == e.ch) begin
            v_key[v] = 1'b0;
            if (!(v_sus[v] || v_sost[v])) push_cmd(seq, CMD_STOP_TAIL, v, 0, e.vel, 0, 0, n);
          end
      REQ_ALL_OFF: begin
        for (int v = 0; v < NUM_VOICES; v++)
          if (v_active[v] && (e.ch == 0 || v_chan[v] == e.ch))
            push_cmd(seq, CMD_STOP_TAIL, v, 0, VEL_ONE, 0, 0, n);
        chan_sus = '0;
      end
      REQ_SUSTAIN: if (ch_ok) begin
        if (e.down) begin
          chan_sus[e.ch - 1] = 1'b1;
          for (int v = 0; v < NUM_VOICES; v++)
            if (v_active[v] && v_chan[v] == e.ch && v_key[v]) v_sus[v] = 1'b1;
        end else begin
          for (int v = 0; v < NUM_VOICES; v++)
            if (v_active[v] && v_chan[v] == e.ch) begin
              v_sus[v] = 1'b0;
              if (!(v_key[v] || v_sost[v])) push_cmd(seq, CMD_STOP_TAIL, v, 0, VEL_ONE, 0, 0, n);
            end
          chan_sus[e.ch - 1] = 1'b0;
        end
      end
      REQ_SOSTENUTO: if (ch_ok) begin
        for (int v = 0; v < NUM_VOICES; v++)
          if (v_active[v] && v_chan[v] == e.ch) begin
            if (e.down) v_sost[v] = 1'b1;
            else if (v_sost[v]) push_cmd(seq, CMD_STOP_TAIL, v, 0, VEL_ONE, 0, 0, n);
          end
      end
      REQ_PITCH: if (ch_ok) chan_pitch[e.ch - 1] = e.wheel;
      REQ_ENDED: if (e.ended < NUM_VOICES) begin
        v_active[e.ended] = 1'b0;
        v_note[e.ended] = '0;
        v_chan[e.ended] = '0;
        v_key[e.ended] = 1'b0;
        v_sus[e.ended] = 1'b0;
        v_sost[e.ended] = 1'b0;
      end
      default: ;
    endcase
    if (n > 0) pending_cmds[pending_cmds.size() - 1].last = 1'b1;
  endfunction

  // sample accepted beats on both channels
  always @(posedge clk) begin
    voice_cmd_t x;
    midi_event_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command beat cmd=%0d voice=%0d", $time,
                 out_bus.command, out_bus.voice_id);
        errors++;
      end else begin
        x = pending_cmds.pop_front();
        if (out_bus.command !== x.cmd || out_bus.voice_id !== x.vid ||
            out_bus.out_note !== x.note || out_bus.out_velocity !== x.vel ||
            out_bus.out_channel !== x.ch || out_bus.out_pitch !== x.pitch ||
            out_bus.last !== x.last) begin
          $display("%0t: event %0d expected cmd=%0d v=%0d n=%0d vel=%0d ch=%0d p=%0d l=%0d",
                   $time, x.seq, x.cmd, x.vid, x.note, x.vel, x.ch, x.pitch, x.last);
          $display("%0t:   actual cmd=%0d v=%0d n=%0d vel=%0d ch=%0d p=%0d l=%0d", $time,
                   out_bus.command, out_bus.voice_id, out_bus.out_note, out_bus.out_velocity,
                   out_bus.out_channel, out_bus.out_pitch, out_bus.last);
          errors++;
        end
        if (x.first && pin_cmd.exists(x.seq) &&
            (x.cmd !== pin_cmd[x.seq] || x.vid !== pin_vid[x.seq])) begin
          $display("%0t: event %0d table expects cmd=%0d v=%0d, got cmd=%0d v=%0d", $time,
                   x.seq, pin_cmd[x.seq], pin_vid[x.seq], x.cmd, x.vid);
          errors++;
        end
      end
    end
    if (rst_n && in_bus.valid && in_bus.ready) begin
      e.req = in_bus.req_type; e.ch = in_bus.channel; e.note = in_bus.note;
      e.vel = in_bus.velocity; e.down = in_bus.pedal_down; e.wheel = in_bus.wheel_value;
      e.ended = in_bus.ended_voice;
      apply_event(e, accepted_cnt);
      accepted_cnt++;
    end
  end

  // command side ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready = 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
      out_bus.ready = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_bus.ready = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_bus.ready = 1'b0;
    end else begin
      out_bus.ready = 1'b1;
      if (!calm && $urandom_range(0, 4) == 0)
        out_gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    end
  end

  task automatic send_event(midi_event_t e, bit [1:0] pc = CMD_NONE, bit [5:0] pv = 0);
    int gap;
    if (pc != CMD_NONE) begin
      pin_cmd[sent_cnt] = pc;
      pin_vid[sent_cnt] = pv;
    end
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.req_type = e.req; in_bus.channel = e.ch; in_bus.note = e.note;
    in_bus.velocity = e.vel; in_bus.pedal_down = e.down; in_bus.wheel_value = e.wheel;
    in_bus.ended_voice = e.ended;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    sent_cnt++;
  endtask

  task automatic wait_idle();
    in_bus.valid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    // events that return nothing may still be in work
    repeat (100) @(negedge clk);
  endtask

  task automatic write_steal(bit en);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = 3'd4 * CFG_STEAL_ENABLE;
    cfg_pwdata = {31'd0, en};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    steal_on = en;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  function automatic midi_event_t mk(logic [2:0] r, logic [4:0] c, logic [6:0] n,
                                     logic [6:0] v, logic d, logic [13:0] w, logic [5:0] x);
    midi_event_t e;
    e.req = r; e.ch = c; e.note = n; e.vel = v; e.down = d; e.wheel = w; e.ended = x;
    return e;
  endfunction

  // well-formed play on a few channels, with some noise
  function automatic midi_event_t rand_event();
    midi_event_t e;
    int k;
    e = mk(REQ_NOTE_ON, 5'($urandom_range(1, 3)), 7'(48 + $urandom_range(0, 11)),
           7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
           14'($urandom_range(0, 16383)), 6'($urandom_range(0, 15)));
    if ($urandom_range(0, 9) == 0) e.note = 7'($urandom_range(0, 127));
    k = $urandom_range(0, 99);
    if (k < 38) e.req = REQ_NOTE_ON;
    else if (k < 62) e.req = REQ_NOTE_OFF;
    else if (k < 70) e.req = REQ_SUSTAIN;
    else if (k < 76) e.req = REQ_SOSTENUTO;
    else if (k < 81) e.req = REQ_PITCH;
    else if (k < 91) e.req = REQ_ENDED;
    else if (k < 93) e.req = REQ_ALL_OFF;
    else begin
      e.req = 3'($urandom_range(0, 7));
      e.ch = 5'($urandom_range(0, 31));
      e.ended = 6'($urandom_range(0, 63));
    end
    return e;
  endfunction

  table_row_t rows [$];

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0; in_bus.req_type = '0; in_bus.channel = '0; in_bus.note = '0;
    in_bus.velocity = '0; in_bus.pedal_down = 1'b0; in_bus.wheel_value = '0;
    in_bus.ended_voice = '0;
    out_bus.ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = '0; cfg_pwdata = '0;
    errors = 0; accepted_cnt = 0; sent_cnt = 0; calm = 1'b0; hold_req = 1'b0;
    hold_cnt = 0; out_gap = 0;
    steal_on = 1'b1; chan_sus = '0; start_count = '0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      v_active[v] = 0; v_note[v] = 0; v_chan[v] = 0; v_age[v] = 0;
      v_key[v] = 0; v_sus[v] = 0; v_sost[v] = 0;
    end
    for (int c = 0; c < NUM_CH; c++) chan_pitch[c] = PITCH_CENTER;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed table: event, then the first command where it is obvious
    rows.push_back('{mk(REQ_NOTE_ON, 1, 60, 100, 0, 0, 0), CMD_START, 0});
    rows.push_back('{mk(REQ_NOTE_ON, 16, 127, 127, 1, 16383, 63), CMD_START, 1});
    rows.push_back('{mk(REQ_NOTE_ON, 1, 0, 0, 0, 0, 0), CMD_START, 2});
    rows.push_back('{mk(REQ_NOTE_ON, 0, 64, 64, 0, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_NOTE_ON, 31, 64, 64, 0, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_PITCH, 1, 0, 0, 0, 16383, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_PITCH, 16, 0, 0, 0, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_PITCH, 0, 0, 0, 0, 5, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_NOTE_ON, 1, 60, 90, 0, 0, 0), CMD_STOP_TAIL, 0});
    rows.push_back('{mk(REQ_SUSTAIN, 1, 0, 0, 1, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_NOTE_OFF, 1, 60, 5, 0, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_SOSTENUTO, 16, 0, 0, 1, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_NOTE_OFF, 16, 127, 33, 0, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_SUSTAIN, 1, 0, 0, 0, 0, 0), CMD_STOP_TAIL, 0});
    rows.push_back('{mk(REQ_SOSTENUTO, 16, 0, 0, 0, 0, 0), CMD_STOP_TAIL, 1});
    rows.push_back('{mk(REQ_NOTE_OFF, 0, 0, 7, 0, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_ALL_OFF, 17, 0, 0, 0, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_ALL_OFF, 0, 0, 0, 0, 0, 0), CMD_STOP_TAIL, 0});
    rows.push_back('{mk(REQ_ENDED, 0, 0, 0, 0, 0, 63), CMD_NONE, 0});
    rows.push_back('{mk(REQ_ENDED, 0, 0, 0, 0, 0, 16), CMD_NONE, 0});
    rows.push_back('{mk(REQ_ENDED, 0, 0, 0, 0, 0, 1), CMD_NONE, 0});
    rows.push_back('{mk(3'd7, 1, 1, 1, 1, 1, 1), CMD_NONE, 0});
    rows.push_back('{mk(REQ_SOSTENUTO, 17, 0, 0, 1, 0, 0), CMD_NONE, 0});
    rows.push_back('{mk(REQ_ALL_OFF, 5, 0, 0, 0, 0, 0), CMD_NONE, 0});
    foreach (rows[i]) send_event(rows[i].ev, rows[i].pin_cmd, rows[i].pin_vid);
    wait_idle();

    // random phases across steal settings; the middle one holds the command side off
    for (int ph = 0; ph < 3; ph++) begin
      write_steal(ph != 1);
      calm = (ph == 2);
      for (int i = 0; i < 35; i++) begin
        if (ph == 1 && i == 10) hold_req = 1'b1;
        if (ph == 2 && i == 20) calm = 1'b0;
        send_event(rand_event());
      end
      wait_idle();
    end
    write_steal(1'b0);
    write_steal(1'b1);
    wait_idle();

    if (errors == 0) begin
      $display("tb_midi_voice_allocator_core: PASS");
    end else begin
      $display("tb_midi_voice_allocator_core: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("tb_midi_voice_allocator_core: FAIL");
    $finish;
  end

endmodule
